/* src/pdsr_pkg.sv */
// Shared types, field widths, register codes and constants for the PD sink request block.
`timescale 1ns / 1ps

package pdsr_pkg;

    // Field widths.
    localparam int VOLT_W  = 16;
    localparam int CURR_W  = 14;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 3;
    localparam int ID_W    = 3;
    localparam int HDR_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream packing widths.
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 56;
    localparam int OUT_TUSER_W  = 2;

    // Default number of offers that are evaluated in one message.
    localparam int MAX_OFFERS_DEF = 7;

    // Register reset values.
    localparam logic [VOLT_W-1:0] MIN_VOLTAGE_RST = 16'd5000;
    localparam logic [VOLT_W-1:0] MAX_VOLTAGE_RST = 16'd12800;
    localparam logic [CURR_W-1:0] MIN_CURRENT_RST = 14'd500;
    localparam logic [CURR_W-1:0] MAX_CURRENT_RST = 14'd2000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLTAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLTAGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CURRENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT = 2'd3;

    // Power data object type codes (bits 31:30).
    localparam logic [1:0] PDO_FIXED     = 2'd0;
    localparam logic [1:0] PDO_AUGMENTED = 2'd3;
    // Augmented subtype for a standard-range programmable supply (bits 29:28).
    localparam logic [1:0] APDO_SPR_PPS  = 2'd0;

    // Request header pieces.
    localparam logic [1:0] SPEC_REV_3_0 = 2'd2;
    localparam logic [4:0] MSG_REQUEST  = 5'd2;

    // Sink limits as held in the configuration registers.
    typedef struct packed {
        logic [VOLT_W-1:0] min_voltage_mv;
        logic [VOLT_W-1:0] max_voltage_mv;
        logic [CURR_W-1:0] min_current_ma;
        logic [CURR_W-1:0] max_current_ma;
    } cfg_t;

    // Final selection of a message.
    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] offer;
    } sel_t;

    // One result word.
    typedef struct packed {
        logic              found;
        logic              is_pps;
        logic [POS_W-1:0]  chosen_position;
        logic [WORD_W-1:0] request_word;
        logic [HDR_W-1:0]  header_word;
    } res_t;

endpackage

/* src/pd_sink_pdo_select_request_top.sv */
// Top level of the PD sink offer selector and request builder.
// A final offer word moves through the input register, selection register and output register.
// Throughput: one offer word per cycle; the output register lets input continue while a result
// waits; backpressure that also fills the selection register stalls only a final offer word.
// Reset: asynchronous active-low rst_n clears the stage valids, the offer tracker and
// restores the limit registers to their defaults; no clearing pass follows.
`timescale 1ns / 1ps

module pd_sink_pdo_select_request_top
    import pdsr_pkg::*;
#(
    parameter int MAX_OFFERS = MAX_OFFERS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: offer_word [31:0], message_id [34:32], zero fill [39:35].
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tlast: last_offer.
    input  logic                   s_tlast,
    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: chosen_position [2:0], request_word [34:3], header_word [50:35], zero [55:51].
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: found [0], is_pps [1].
    output logic [OUT_TUSER_W-1:0] m_tuser,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t              cfg;
    sel_t              sel;
    res_t              res;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_last_reg;
    logic [ID_W-1:0]   in_id_reg;

    logic              sel_valid_reg;
    logic              sel_valid_next;
    sel_t              sel_reg;
    logic [ID_W-1:0]   sel_id_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;
    logic [OUT_TUSER_W-1:0] out_tuser_reg;

    logic              accept_in;
    logic              out_free;
    logic              sel_free;
    logic              item_en;
    logic              load_sel;
    logic              load_out;

    assign cfg_ready = 1'b1;

    pdsr_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Stage flow control.
    assign out_free  = !out_valid_reg || m_tready;
    assign sel_free  = !sel_valid_reg || out_free;
    assign item_en   = in_valid_reg && (!in_last_reg || sel_free);
    assign load_sel  = item_en && in_last_reg;
    assign load_out  = sel_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || item_en;
    assign accept_in = s_tvalid && s_tready;

    assign in_valid_next  = accept_in ? 1'b1 : (item_en ? 1'b0 : in_valid_reg);
    assign sel_valid_next = load_sel ? 1'b1 : (load_out ? 1'b0 : sel_valid_reg);
    assign out_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    pdsr_offer_eval #(
        .MAX_OFFERS (MAX_OFFERS)
    ) u_offer_eval
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_en    (item_en),
        .offer_word (in_word_reg),
        .last_offer (in_last_reg),
        .sel        (sel)
    );

    pdsr_request_build u_request_build
    (
        .cfg        (cfg),
        .sel        (sel_reg),
        .message_id (sel_id_reg),
        .res        (res)
    );

    // Stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sel_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            sel_valid_reg <= sel_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_word_reg <= s_tdata[WORD_W-1:0];
            in_id_reg   <= s_tdata[WORD_W+ID_W-1:WORD_W];
            in_last_reg <= s_tlast;
        end
        if (load_sel)
        begin
            sel_reg    <= sel;
            sel_id_reg <= in_id_reg;
        end
        if (load_out)
        begin
            out_tdata_reg <= OUT_TDATA_W'({res.header_word, res.request_word,
                                           res.chosen_position});
            out_tuser_reg <= {res.is_pps, res.found};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

endmodule

/* src/pdsr_cfg_regs.sv */
// Configuration register file holding the sink voltage and current limits.
`timescale 1ns / 1ps

module pdsr_cfg_regs
    import pdsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index of a write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_MIN_VOLTAGE: cfg_next.min_voltage_mv = wr_data;
                CFG_MAX_VOLTAGE: cfg_next.max_voltage_mv = wr_data;
                CFG_MIN_CURRENT: cfg_next.min_current_ma = wr_data[CURR_W-1:0];
                CFG_MAX_CURRENT: cfg_next.max_current_ma = wr_data[CURR_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_voltage_mv <= MIN_VOLTAGE_RST;
            cfg_reg.max_voltage_mv <= MAX_VOLTAGE_RST;
            cfg_reg.min_current_ma <= MIN_CURRENT_RST;
            cfg_reg.max_current_ma <= MAX_CURRENT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/pdsr_offer_eval.sv */
// Offer matcher and best-offer tracker across the objects of one message.
`timescale 1ns / 1ps

module pdsr_offer_eval
    import pdsr_pkg::*;
#(
    parameter int MAX_OFFERS = MAX_OFFERS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              item_en,
    input  logic [WORD_W-1:0] offer_word,
    input  logic              last_offer,
    output sel_t              sel
);

    localparam logic [POS_W-1:0] OfferLimit = POS_W'(MAX_OFFERS);

    logic [POS_W-1:0]  offer_count_reg;
    logic [POS_W-1:0]  offer_count_next;
    logic [POS_W-1:0]  best_position_reg;
    logic [POS_W-1:0]  best_position_next;
    logic [WORD_W-1:0] best_offer_reg;
    logic [WORD_W-1:0] best_offer_next;

    logic [VOLT_W-1:0] fixed_mv;
    logic [CURR_W-1:0] fixed_ma;
    logic [VOLT_W-1:0] pps_mv;
    logic [CURR_W-1:0] pps_ma;
    logic              fixed_ok;
    logic              pps_ok;
    logic              match;
    logic              in_range;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  upd_position;
    logic [WORD_W-1:0] upd_offer;

    // Scale the offer fields to millivolts and milliamps.
    assign fixed_mv = VOLT_W'(offer_word[19:10]) * 16'd50;
    assign fixed_ma = CURR_W'(offer_word[9:0]) * 14'd10;
    assign pps_mv   = VOLT_W'(offer_word[24:17]) * 16'd100;
    assign pps_ma   = CURR_W'(offer_word[6:0]) * 14'd50;

    // Limit checks for the two offer kinds that can match.
    assign fixed_ok = (offer_word[31:30] == PDO_FIXED)
                    && (fixed_mv <= cfg.max_voltage_mv)
                    && (fixed_mv >= cfg.min_voltage_mv)
                    && (fixed_ma >= cfg.min_current_ma);
    assign pps_ok   = (offer_word[31:30] == PDO_AUGMENTED)
                    && (offer_word[29:28] == APDO_SPR_PPS)
                    && (pps_mv >= cfg.min_voltage_mv)
                    && (pps_ma >= cfg.min_current_ma);
    assign match    = fixed_ok || pps_ok;

    // Positions past the limit are not evaluated.
    assign in_range = offer_count_reg < OfferLimit;
    assign pos      = offer_count_reg + POS_W'(1);

    // Best offer including the current object.
    always_comb
    begin
        upd_position = best_position_reg;
        upd_offer    = best_offer_reg;
        if (in_range && match)
        begin
            upd_position = pos;
            upd_offer    = offer_word;
        end
    end

    // State update; the end of a message clears the tracker.
    always_comb
    begin
        offer_count_next   = offer_count_reg;
        best_position_next = best_position_reg;
        best_offer_next    = best_offer_reg;
        if (item_en)
        begin
            if (last_offer)
            begin
                offer_count_next   = '0;
                best_position_next = '0;
                best_offer_next    = '0;
            end
            else
            begin
                if (in_range)
                begin
                    offer_count_next = pos;
                end
                best_position_next = upd_position;
                best_offer_next    = upd_offer;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offer_count_reg   <= '0;
            best_position_reg <= '0;
            best_offer_reg    <= '0;
        end
        else
        begin
            offer_count_reg   <= offer_count_next;
            best_position_reg <= best_position_next;
            best_offer_reg    <= best_offer_next;
        end
    end

    // Selection handed on when the final object is taken.
    assign sel.found    = (upd_position != '0);
    assign sel.position = upd_position;
    assign sel.offer    = upd_offer;

endmodule

/* src/pdsr_request_build.sv */
// Request data object and message header builder for the chosen offer.
`timescale 1ns / 1ps

module pdsr_request_build
    import pdsr_pkg::*;
(
    input  cfg_t            cfg,
    input  sel_t            sel,
    input  logic [ID_W-1:0] message_id,
    output res_t            res
);

    // Divide by ten through a reciprocal; exact for inputs below 10240, where the quotient fits 10 bits.
    function automatic logic [9:0] div10(input logic [CURR_W-1:0] x);
        logic [29:0] prod;
        prod = 30'(x) * 30'd52429;
        return prod[28:19];
    endfunction

    // Divide by fifty; exact for inputs below 6400, where the quotient fits 7 bits.
    function automatic logic [6:0] div50(input logic [CURR_W-1:0] x);
        logic [29:0] prod;
        prod = 30'(x) * 30'd41944;
        return prod[27:21];
    endfunction

    // Divide by twenty; exact over the 16-bit range.
    function automatic logic [11:0] div20(input logic [VOLT_W-1:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'd52429;
        return prod[31:20];
    endfunction

    logic              pps;
    logic [CURR_W-1:0] fix_ma;
    logic [9:0]        fix_units;
    logic [CURR_W-1:0] pps_ma;
    logic [6:0]        pps_units;
    logic [VOLT_W-1:0] pps_mv;
    logic [11:0]       pps_volt;
    logic [WORD_W-1:0] request;
    logic [HDR_W-1:0]  header;

    assign pps = (sel.offer[31:30] == PDO_AUGMENTED);

    // Fixed offer: current clamped to the sink maximum, in 10 mA units.
    assign fix_ma    = CURR_W'(sel.offer[9:0]) * 14'd10;
    assign fix_units = (cfg.max_current_ma < fix_ma) ? div10(cfg.max_current_ma)
                                                      : sel.offer[9:0];

    // Programmable offer: current in 50 mA units, voltage in 20 mV units.
    assign pps_ma    = CURR_W'(sel.offer[6:0]) * 14'd50;
    assign pps_units = (cfg.max_current_ma < pps_ma) ? div50(cfg.max_current_ma)
                                                      : sel.offer[6:0];
    assign pps_mv    = VOLT_W'(sel.offer[24:17]) * 16'd100;
    assign pps_volt  = (cfg.max_voltage_mv < pps_mv) ? div20(cfg.max_voltage_mv)
                                                      : 12'(sel.offer[24:17]) * 12'd5;

    // Assemble the request object.
    always_comb
    begin
        request        = '0;
        request[30:28] = sel.position;
        request[25]    = 1'b1;
        request[24]    = 1'b1;
        if (pps)
        begin
            request[20:9] = pps_volt;
            request[6:0]  = pps_units;
        end
        else
        begin
            request[19:10] = fix_units;
            request[9:0]   = fix_units;
        end
    end

    // Header: one data object, message id, revision 3.0, request message.
    always_comb
    begin
        header        = '0;
        header[12]    = 1'b1;
        header[11:9]  = message_id;
        header[7:6]   = SPEC_REV_3_0;
        header[4:0]   = MSG_REQUEST;
    end

    // Everything reads as zero when nothing matched.
    assign res.found           = sel.found;
    assign res.is_pps          = sel.found && pps;
    assign res.chosen_position = sel.found ? sel.position : '0;
    assign res.request_word    = sel.found ? request : '0;
    assign res.header_word     = sel.found ? header : '0;

endmodule

/* src/pdsr_checker.sv */
// Port-level checker for the PD sink request block, bound to the top level.
`timescale 1ns / 1ps

module pdsr_checker
    import pdsr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [OUT_TUSER_W-1:0] m_tuser
);

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A word without a match carries all zeros and no programmable flag.
    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("no-match result word is not all zero");

    // A match always names a position and has the fixed request bits set.
    a_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[2:0] != 3'd0) && m_tdata[27] && m_tdata[28]
                                   && (m_tdata[33:31] == m_tdata[2:0]))
        else $error("matched request word is malformed");

    // A matched header has one data object, revision 3.0 and request type.
    a_header_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[47] && (m_tdata[42:41] == SPEC_REV_3_0)
                                   && (m_tdata[39:35] == MSG_REQUEST)
                                   && (m_tdata[55:51] == 5'd0))
        else $error("request header is malformed");

endmodule

bind pd_sink_pdo_select_request_top pdsr_checker u_pdsr_checker (.*);
